@@ rtl/core/clist_pkg.sv @@
// Shared package for the circular list engine: field widths, command and
// status codes, cell action codes and the control word broadcast to the cells.
// No dependencies.
`default_nettype none

package clist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int POS_W        = 5;

    localparam logic [CMD_W-1:0] CMD_INS_END = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BEG = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // what every cell does under the broadcast control word
    typedef enum logic [2:0] {
        ACT_HOLD    = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_PREPEND = 3'd2,
        ACT_COMPARE = 3'd3,
        ACT_CLOSE   = 3'd4,
        ACT_ROTATE  = 3'd5
    } act_t;

    typedef struct packed {
        act_t                     act;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/clist_ifs.sv @@
// Valid/ready channel interfaces: request channel (cmd, value) and
// result channel (status, position, element, last_of_run). Uses clist_pkg.
`default_nettype none

interface clist_req_if;
    import clist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface clist_rsp_if;
    import clist_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] element;
    logic                     last_of_run;

    modport source (output valid, output status, output position, output element,
                    output last_of_run, input ready);
    modport sink   (input valid, input status, input position, input element,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/core/clist_cell.sv @@
// One list cell: holds one stored value and its match flag, takes data
// from its neighbors under the broadcast action. Uses clist_pkg.
`default_nettype none

module clist_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 6
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  clist_pkg::cell_ctrl_t                ctrl,
    input  wire  [CW-1:0]                        count,
    input  wire                                  ge,
    input  wire  signed [clist_pkg::DATA_W-1:0]  left_val,
    input  wire  signed [clist_pkg::DATA_W-1:0]  right_val,
    input  wire  signed [clist_pkg::DATA_W-1:0]  head_val,
    output logic signed [clist_pkg::DATA_W-1:0]  value,
    output logic                                 match
);
    import clist_pkg::*;

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     match_reg, match_next;
    logic [CW-1:0]            tail;

    assign tail = count - CW'(1);

    always_comb
    begin
        value_next = value_reg;
        match_next = match_reg;
        unique case (ctrl.act)
            ACT_HOLD:
            begin
                value_next = value_reg;
            end
            ACT_APPEND:
            begin
                if (IDX == count)
                    value_next = ctrl.value;
            end
            ACT_PREPEND:
            begin
                value_next = (INDEX == 0) ? ctrl.value : left_val;
            end
            ACT_COMPARE:
            begin
                match_next = (value_reg == ctrl.value) && (IDX < count);
            end
            ACT_CLOSE:
            begin
                // close the gap from the deleted cell onward
                if (ge)
                    value_next = right_val;
            end
            ACT_ROTATE:
            begin
                // the head wraps around to the tail
                if (IDX < tail)
                    value_next = right_val;
                else if (IDX == tail)
                    value_next = head_val;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

@@ rtl/core/clist_chain.sv @@
// Row of list cells wired neighbor to neighbor; exposes the head value
// and the match flags. Uses clist_pkg and clist_cell.
`default_nettype none

module clist_chain #(
    parameter int CAPACITY = 32,
    parameter int CW       = 6
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  clist_pkg::cell_ctrl_t                ctrl,
    input  wire  [CW-1:0]                        count,
    input  wire  [CAPACITY-1:0]                  ge_mask,
    output logic signed [clist_pkg::DATA_W-1:0]  head,
    output logic [CAPACITY-1:0]                  match_vec
);
    import clist_pkg::*;

    logic signed [DATA_W-1:0] vals [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = ctrl.value;
        end
        else
        begin : g_mid_l
            assign left_val = vals[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = vals[g];
        end
        else
        begin : g_mid_r
            assign right_val = vals[g+1];
        end

        clist_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count),
            .ge        (ge_mask[g]),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (vals[0]),
            .value     (vals[g]),
            .match     (match_vec[g])
        );
    end

    assign head = vals[0];

endmodule

`default_nettype wire

@@ rtl/core/circular_list_engine.sv @@
// Top level of the circular list engine: command sequencer, entry count,
// result register and the cell chain. Uses clist_pkg, clist_ifs, clist_chain.
//
//   channel  dir  fields                                    handshake
//   req      in   cmd, value                                valid/ready
//   rsp      out  status, position, element, last_of_run    valid/ready
//
// Inserts answer when accepted; search and delete go from ST_IDLE to ST_MATCH
// (cells compare, then the first match is picked and, for a delete, the gap is
// closed through the chain). Display gives one result per stored value: the
// chain rotates one step per result, so it ends in its original order.
// Reset clears the count, the sequencer and the result valid; stored values
// are not cleared. A stalled result holds the sequencer and the chain.
`default_nettype none

module circular_list_engine #(
    parameter int CAPACITY = clist_pkg::CAPACITY_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    clist_req_if.sink   req,
    clist_rsp_if.source rsp
);
    import clist_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_SHOW  = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            disp_reg, disp_next;
    logic                     del_reg, del_next;

    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] elem_reg, elem_next;
    logic                     last_reg, last_next;

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] head;
    logic [CAPACITY-1:0]      match_vec, neg_vec, first_oh, ge_mask;
    logic [IW-1:0]            first_idx;
    logic [IW+POS_W-1:0]      first_ext;
    logic [CW+POS_W-1:0]      disp_ext;
    logic                     can_load, accept, full, disp_last;

    assign can_load  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && can_load;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign disp_last = (disp_reg == count_reg - CW'(1));

    // lowest match and everything at or above it
    assign neg_vec  = ~match_vec + CAPACITY'(1);
    assign first_oh = match_vec & neg_vec;
    assign ge_mask  = match_vec | neg_vec;

    always_comb
    begin
        first_idx = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (first_oh[k])
                first_idx = first_idx | IW'(k);
        end
    end

    assign first_ext = {{POS_W{1'b0}}, first_idx};
    assign disp_ext  = {{POS_W{1'b0}}, disp_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        disp_next      = disp_reg;
        del_next       = del_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        pos_next       = pos_reg;
        elem_next      = elem_reg;
        last_next      = last_reg;
        ctrl.act       = ACT_HOLD;
        ctrl.value     = req.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next  = '0;
                    elem_next = '0;
                    last_next = 1'b1;
                    unique case (req.cmd)
                        CMD_INS_END, CMD_INS_BEG:
                        begin
                            rsp_valid_next = 1'b1;
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                status_next = STAT_OK;
                                count_next  = count_reg + CW'(1);
                                ctrl.act    = (req.cmd == CMD_INS_END) ? ACT_APPEND
                                                                       : ACT_PREPEND;
                            end
                        end
                        CMD_SEARCH:
                        begin
                            ctrl.act   = ACT_COMPARE;
                            del_next   = 1'b0;
                            state_next = ST_MATCH;
                        end
                        CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                            end
                            else
                            begin
                                ctrl.act   = ACT_COMPARE;
                                del_next   = 1'b1;
                                state_next = ST_MATCH;
                            end
                        end
                        CMD_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = STAT_EMPTY;
                            end
                            else
                            begin
                                disp_next  = '0;
                                state_next = ST_SHOW;
                            end
                        end
                        default:
                        begin
                            // drop unknown commands
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MATCH:
            begin
                if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    pos_next       = '0;
                    elem_next      = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    if (match_vec == '0)
                        status_next = STAT_NOT_FOUND;
                    else
                    begin
                        status_next = STAT_OK;
                        if (del_reg)
                        begin
                            ctrl.act   = ACT_CLOSE;
                            count_next = count_reg - CW'(1);
                        end
                        else
                            pos_next = first_ext[POS_W-1:0];
                    end
                end
            end
            ST_SHOW:
            begin
                if (can_load)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = STAT_OK;
                    pos_next       = disp_ext[POS_W-1:0];
                    elem_next      = head;
                    last_next      = disp_last;
                    ctrl.act       = ACT_ROTATE;
                    disp_next      = disp_reg + CW'(1);
                    if (disp_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            disp_reg      <= '0;
            del_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            disp_reg      <= disp_next;
            del_reg       <= del_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pos_reg    <= pos_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    clist_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (count_reg),
        .ge_mask   (ge_mask),
        .head      (head),
        .match_vec (match_vec)
    );

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = pos_reg;
    assign rsp.element     = elem_reg;
    assign rsp.last_of_run = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_APPEND || ctrl.act == ACT_PREPEND) |-> !full)
        else $error("insert issued to a full chain");

    a_show_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHOW) |-> (disp_reg < count_reg))
        else $error("display index past the tail");

    a_close_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_CLOSE) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("delete did not shrink the list");

endmodule

`default_nettype wire

@@ test/tb_circular_list_engine.sv @@
`timescale 1ns / 1ps
// Testbench for circular_list_engine: directed and random list commands, each
// result checked against a queue-based model of the list kept here.
// Depends on clist_pkg, clist_ifs (clist_req_if, clist_rsp_if) and the engine RTL.

module tb_circular_list_engine;
    import clist_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 160;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    // allow for requests that each stream a full list with the longest response
    // stall on every result
    localparam int RUN_LIMIT    = 2_000_000;

    // command codes the engine has no use for
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] element;
        logic                     last_of_run;
    } list_result_t;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } mix_bias_t;

    logic clk;
    logic rst_n;

    clist_req_if req_ch ();
    clist_rsp_if rsp_ch ();

    circular_list_engine #(
        .CAPACITY (LIST_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [DATA_W-1:0] list_model[$];
    list_result_t             pending_results[$];
    logic signed [DATA_W-1:0] value_pool[8];

    bit req_idle_on;
    bit rsp_stall_on;
    int stall_left;
    int cycle_count;
    int mismatch_count;
    int results_checked;
    int requests_sent;
    int random_items;
    int peak_depth;
    int full_count;
    int empty_count;
    int miss_count;
    int display_runs;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] result %0d: %s got %0h expected %0h",
                     $time, results_checked, what, got, want);
    endtask

    // check each accepted result, then pick the next ready
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, element",
                                    rsp_ch.element, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", DATA_W'(rsp_ch.status),
                                        DATA_W'(want.status));
                    if (rsp_ch.position !== want.position)
                        report_mismatch("position", DATA_W'(rsp_ch.position),
                                        DATA_W'(want.position));
                    if (rsp_ch.element !== want.element)
                        report_mismatch("element", rsp_ch.element, want.element);
                    if (rsp_ch.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", DATA_W'(rsp_ch.last_of_run),
                                        DATA_W'(want.last_of_run));
                end
                results_checked++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(rsp_stall_on);
                rsp_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    function automatic int find_first(input logic signed [DATA_W-1:0] data);
        for (int i = 0; i < list_model.size(); i++)
            if (list_model[i] == data)
                return i;
        return -1;
    endfunction

    // update the list model for one accepted request and queue its results
    function automatic void apply_list_command(input logic [CMD_W-1:0] cmd_code,
                                               input logic signed [DATA_W-1:0] data);
        list_result_t res;
        int hit;
        res = '0;
        res.last_of_run = 1'b1;
        case (cmd_code)
            CMD_INS_END, CMD_INS_BEG:
            begin
                if (list_model.size() >= LIST_DEPTH)
                begin
                    res.status = STAT_FULL;
                    full_count++;
                end
                else
                begin
                    if (cmd_code == CMD_INS_END)
                        list_model.push_back(data);
                    else
                        list_model.push_front(data);
                    res.status = STAT_OK;
                    if (list_model.size() > peak_depth)
                        peak_depth = list_model.size();
                end
                pending_results.push_back(res);
            end
            CMD_SEARCH:
            begin
                hit = find_first(data);
                if (hit >= 0)
                begin
                    res.status = STAT_OK;
                    res.position = hit[POS_W-1:0];
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                    miss_count++;
                end
                pending_results.push_back(res);
            end
            CMD_DELETE:
            begin
                hit = find_first(data);
                if (list_model.size() == 0)
                begin
                    res.status = STAT_EMPTY;
                    empty_count++;
                end
                else if (hit >= 0)
                begin
                    list_model.delete(hit);
                    res.status = STAT_OK;
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                    miss_count++;
                end
                pending_results.push_back(res);
            end
            CMD_DISPLAY:
            begin
                display_runs++;
                if (list_model.size() == 0)
                begin
                    res.status = STAT_EMPTY;
                    empty_count++;
                    pending_results.push_back(res);
                end
                else
                begin
                    for (int i = 0; i < list_model.size(); i++)
                    begin
                        res.status = STAT_OK;
                        res.position = i[POS_W-1:0];
                        res.element = list_model[i];
                        res.last_of_run = (i == list_model.size() - 1);
                        pending_results.push_back(res);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_request(input logic [CMD_W-1:0] cmd_code,
                                input logic signed [DATA_W-1:0] data);
        int gap;
        gap = pick_gap(req_idle_on);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd   <= CMD_W'($urandom_range(0, 7));
            req_ch.value <= $urandom;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd_code;
        req_ch.value <= data;
        do
            @(posedge clk);
        while (!req_ch.ready);
        requests_sent++;
        apply_list_command(cmd_code, data);
    endtask

    // hold the sender until every pending result has come back
    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() > 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input mix_bias_t bias);
        int ins_pct;
        int del_pct;
        int r;
        case (bias)
            MIX_GROW:
            begin
                ins_pct = 70;
                del_pct = 10;
            end
            MIX_SHRINK:
            begin
                ins_pct = 20;
                del_pct = 55;
            end
            default:
            begin
                ins_pct = 40;
                del_pct = 30;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 3)
            return CMD_W'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
        if (r < 10)
            return CMD_DISPLAY;
        if (r < 10 + ins_pct)
            return $urandom_range(0, 1) ? CMD_INS_END : CMD_INS_BEG;
        if (r < 10 + ins_pct + del_pct)
            return CMD_DELETE;
        return CMD_SEARCH;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_operand(input logic [CMD_W-1:0] cmd_code);
        if ((cmd_code == CMD_SEARCH || cmd_code == CMD_DELETE) && list_model.size() > 0
            && $urandom_range(0, 9) < 6)
            return list_model[$urandom_range(0, list_model.size() - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_list();
        send_request(CMD_DISPLAY, $urandom);
        send_request(CMD_SEARCH, 32'sd0);
        send_request(CMD_DELETE, 32'sd5);
        // unused codes must be swallowed without a result
        for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_UNUSED; c++)
            send_request(c[CMD_W-1:0], $urandom);
        wait_drain();
    endtask

    task automatic test_edge_values();
        send_request(CMD_INS_END, 32'sh8000_0000);
        send_request(CMD_INS_BEG, 32'sh7fff_ffff);
        send_request(CMD_INS_END, 32'sd0);
        send_request(CMD_INS_BEG, -32'sd1);
        send_request(CMD_INS_END, 32'sh8000_0000);
        send_request(CMD_DISPLAY, 32'sd0);
        send_request(CMD_SEARCH, 32'sh8000_0000);
        send_request(CMD_SEARCH, 32'sh1234_5678);
        // duplicates: only the first copy goes
        send_request(CMD_DELETE, 32'sh8000_0000);
        send_request(CMD_DELETE, 32'sh55aa_55aa);
        send_request(CMD_DELETE, -32'sd1);
        send_request(CMD_DELETE, 32'sh8000_0000);
        send_request(CMD_DISPLAY, $urandom);
        send_request(CMD_SEARCH, 32'sd0);
        wait_drain();
    endtask

    task automatic test_full_list();
        while (list_model.size() < LIST_DEPTH)
            send_request($urandom_range(0, 1) ? CMD_INS_END : CMD_INS_BEG, $urandom);
        send_request(CMD_INS_END, $urandom);
        send_request(CMD_INS_BEG, $urandom);
        send_request(CMD_SEARCH, list_model[LIST_DEPTH - 1]);
        wait_drain();
        send_request(CMD_DISPLAY, $urandom);
        while (list_model.size() > 0)
        begin
            if ($urandom_range(0, 4) == 0)
                send_request(CMD_SEARCH, $urandom);
            send_request(CMD_DELETE, list_model[$urandom_range(0, list_model.size() - 1)]);
        end
        send_request(CMD_DISPLAY, $urandom);
        wait_drain();
    endtask

    task automatic test_random_mix();
        mix_bias_t                bias;
        logic [CMD_W-1:0]         cmd_code;
        int                       burst_idx;
        burst_idx = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            bias = mix_bias_t'($urandom_range(0, 2));
            // every fourth burst runs with neither side idling
            req_idle_on  = (burst_idx % 4 != 3) && ($urandom_range(0, 3) != 0);
            rsp_stall_on = (burst_idx % 4 != 3) && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(10, 30))
            begin
                cmd_code = pick_command(bias);
                send_request(cmd_code, pick_operand(cmd_code));
                if (cmd_code <= CMD_DISPLAY)
                    random_items++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drain();
            burst_idx++;
        end
        req_idle_on  = 1'b1;
        rsp_stall_on = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_INS_END;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        req_idle_on  = 1'b1;
        rsp_stall_on = 1'b1;
        value_pool   = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1,
                         $urandom, $urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_mix();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d requests (%0d random), checked %0d results",
                 requests_sent, random_items, results_checked);
        $display("list peaked at %0d of %0d; %0d full, %0d empty, %0d misses, %0d displays",
                 peak_depth, LIST_DEPTH, full_count, empty_count, miss_count, display_runs);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
